>>> src/gmw_pkg.sv
// ----------------------------------------------------------------------------
// gmw_pkg: shared types and helpers for the morphology window filter
// Widths, register indexes, window column type and min/max select.
// ----------------------------------------------------------------------------
`default_nettype none

package gmw_pkg;

   localparam int PIX_W      = 8;
   localparam int X_W        = 11;
   localparam int Y_W        = 12;
   localparam int WID_W      = 12;
   localparam int HGT_W      = 13;
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_RADIUS = 3;
   localparam int NLINES     = 2 * MAX_RADIUS;
   localparam int WSIDE      = NLINES + 1;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int SLOT_W     = $clog2(NLINES);
   localparam int SPAN_W     = $clog2(WSIDE);
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 13;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [WSIDE-1:0] column_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MODE        = 2'd0,
      CSR_WINDOW_SIZE = 2'd1,
      CSR_IMAGE_WIDTH = 2'd2,
      CSR_IMAGE_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              mode;   // 1: dilate (max), 0: erode (min)
      logic [SPAN_W-1:0] span;   // window side minus one
   } win_ctl_type;

   typedef struct packed {
      logic           emit;
      logic           last;
      logic [Y_W-1:0] oy;
      logic [X_W-1:0] ox;
   } meta_type;

   function automatic pix_type pick(input pix_type a, input pix_type b, input logic mode);
      if (mode) return (a > b) ? a : b;
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type ident(input logic mode);
      return mode ? '0 : '1;
   endfunction

endpackage

`default_nettype wire

>>> src/gmw_line_row.sv
// ----------------------------------------------------------------------------
// gmw_line_row: one line buffer row
// Single write port, registered read (old data on same-address write).
// ----------------------------------------------------------------------------
`default_nettype none

module gmw_line_row (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic                       wen,
   input  wire logic [gmw_pkg::ADDR_W-1:0] addr,
   input  wire gmw_pkg::pix_type           wdata,
   output gmw_pkg::pix_type                rdata
);
   import gmw_pkg::*;

   pix_type mem [MAX_WIDTH];
   pix_type q_ff;

   always_ff @(posedge clock) begin
      if (wen) mem[addr] <= wdata;
      if (en) q_ff <= mem[addr];
   end

   assign rdata = q_ff;

endmodule

`default_nettype wire

>>> src/gmw_cell.sv
// ----------------------------------------------------------------------------
// gmw_cell: one window column
// Holds a column of samples, passes it to the next cell on each shift, and
// registers the masked min/max of its column.
// ----------------------------------------------------------------------------
`default_nettype none

module gmw_cell (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic                 shift,
   input  wire gmw_pkg::win_ctl_type ctl,
   input  wire logic                 col_on,
   input  wire gmw_pkg::column_type  col_in,
   output gmw_pkg::column_type       col_out,
   output gmw_pkg::pix_type          red_out
);
   import gmw_pkg::*;

   column_type col_ff;
   pix_type    red_ff;
   pix_type    red_in;

   always_comb begin
      red_in = ident(ctl.mode);
      for (int d = 0; d < WSIDE; d++) begin
         if (col_on && (SPAN_W'(d) <= ctl.span)) red_in = pick(red_in, col_ff[d], ctl.mode);
      end
   end

   always_ff @(posedge clock) begin
      if (shift) col_ff <= col_in;
      if (en) red_ff <= red_in;
   end

   assign col_out = col_ff;
   assign red_out = red_ff;

endmodule

`default_nettype wire

>>> src/grayscale_morphology_window_filter_top.sv
// ----------------------------------------------------------------------------
// grayscale_morphology_window_filter_top: streaming grayscale erode/dilate
// Square-window min/max over a raster pixel stream with line buffers.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one 8-bit pixel per transaction in raster order; tuser marks
//   the first pixel of a frame. rsp_ carries one result per interior pixel with
//   its centre coordinates; tlast flags the final interior pixel of a frame.
//   csr_ writes mode, window size, width and height; write only while idle.
//   Throughput: one pixel per clock while the skid is empty. The line buffer rows read and
//   write one column per cycle when not stalled, and the window cells shift one column per item.
//   Pipeline: an accepted pixel passes line read, window shift, column reduce,
//   then row reduce into the result register.
//   Border pixels produce no transaction.
//   Reset clears control state and restores the register defaults; no
//   clearing pass runs, so pixels are taken right away.
//   When rsp_tready is low, the result register and a one-entry skid hold
//   data; req_tready drops only once the skid is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module grayscale_morphology_window_filter_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [7:0]                     req_tdata,   // [7:0] pixel
   input  wire logic                           req_tuser,   // [0] start_of_frame
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [31:0]                         rsp_tdata,   // [7:0] result, [18:8] out_x,
                                                            // [30:19] out_y, [31] zero
   output logic                                rsp_tlast,
   input  wire logic                           csr_wen,
   input  wire logic [gmw_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [gmw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gmw_pkg::*;

   typedef struct packed {
      logic           last;
      logic [Y_W-1:0] oy;
      logic [X_W-1:0] ox;
      pix_type        res;
   } rsp_type;

   // configuration
   logic             mode_ff;
   logic [2:0]       wsize_ff;
   logic [WID_W-1:0] width_ff;
   logic [HGT_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         wsize_ff  <= 3'd3;
         width_ff  <= WID_W'(640);
         height_ff <= HGT_W'(480);
      end else if (csr_wen) begin
         case (csr_index_type'(csr_addr))
            CSR_MODE:         mode_ff   <= csr_wdata[0];
            CSR_WINDOW_SIZE:  wsize_ff  <= csr_wdata[2:0];
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WID_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HGT_W-1:0];
            default: ;
         endcase
      end
   end

   logic [WID_W-1:0] w_eff;
   logic [HGT_W-1:0] h_eff;
   logic [1:0]       radius;
   win_ctl_type      ctl;

   always_comb begin
      if (width_ff == '0) w_eff = WID_W'(1);
      else if (width_ff > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = HGT_W'(1);
      else if (height_ff > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
      else h_eff = height_ff;
      radius   = (wsize_ff == 3'd0) ? 2'd0 : 2'((wsize_ff - 3'd1) >> 1);
      ctl.mode = mode_ff;
      ctl.span = {radius, 1'b0};
   end

   // pipeline control
   logic en;
   logic accept;
   logic skid_v_ff;
   assign en         = !skid_v_ff;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   // raster position
   logic [X_W-1:0]    col_ff, col_in;
   logic [Y_W-1:0]    row_ff, row_in;
   logic [SLOT_W-1:0] ymod_ff, ymod_in;
   logic [X_W-1:0]    x;
   logic [Y_W-1:0]    y;
   logic [SLOT_W-1:0] ymod;
   logic [WID_W-1:0]  x_next;
   logic [HGT_W-1:0]  y_next;
   meta_type          meta_in;

   always_comb begin
      x    = req_tuser ? '0 : col_ff;
      y    = req_tuser ? '0 : row_ff;
      ymod = req_tuser ? '0 : ymod_ff;
      meta_in.emit = ({1'b0, x} < w_eff) && ({1'b0, y} < h_eff)
                     && (X_W'(ctl.span) <= x) && (Y_W'(ctl.span) <= y);
      meta_in.last = ({1'b0, x} == w_eff - WID_W'(1)) && ({1'b0, y} == h_eff - HGT_W'(1));
      meta_in.ox   = x - X_W'(radius);
      meta_in.oy   = y - Y_W'(radius);
      x_next  = {1'b0, x} + WID_W'(1);
      y_next  = {1'b0, y} + HGT_W'(1);
      col_in  = x_next[X_W-1:0];
      row_in  = y;
      ymod_in = ymod;
      if (x_next >= w_eff) begin
         col_in = '0;
         if (y_next >= h_eff) begin
            row_in  = '0;
            ymod_in = '0;
         end else begin
            row_in  = y_next[Y_W-1:0];
            ymod_in = (ymod == SLOT_W'(NLINES - 1)) ? '0 : ymod + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         ymod_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         ymod_ff <= ymod_in;
      end
   end

   // line buffers
   pix_type q [NLINES];

   for (genvar k = 0; k < NLINES; k++) begin : g_line
      gmw_line_row u_row (
         .clock (clock),
         .en    (en),
         .wen   (accept && (ymod == SLOT_W'(k))),
         .addr  (x),
         .wdata (req_tdata[PIX_W-1:0]),
         .rdata (q[k])
      );
   end

   // stage 1: line data available
   logic              s1_v_ff, s2_v_ff, s3_v_ff;
   meta_type          s1_meta_ff, s2_meta_ff, s3_meta_ff;
   pix_type           s1_px_ff;
   logic [SLOT_W-1:0] s1_ymod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= accept;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (accept) begin
            s1_meta_ff <= meta_in;
            s1_px_ff   <= req_tdata[PIX_W-1:0];
            s1_ymod_ff <= ymod;
         end
         s2_meta_ff <= s1_meta_ff;
         s3_meta_ff <= s2_meta_ff;
      end
   end

   // new column: current pixel on top, older rows below
   column_type        col_vec;
   logic [SLOT_W:0]   slot;

   always_comb begin
      col_vec[0] = s1_px_ff;
      slot       = '0;
      for (int d = 1; d < WSIDE; d++) begin
         slot = {1'b0, s1_ymod_ff} + (SLOT_W+1)'(NLINES - d);
         if (slot >= (SLOT_W+1)'(NLINES)) slot = slot - (SLOT_W+1)'(NLINES);
         col_vec[d] = q[slot[SLOT_W-1:0]];
      end
   end

   // window cells
   column_type cell_col [WSIDE];
   pix_type    cell_red [WSIDE];

   for (genvar j = 0; j < WSIDE; j++) begin : g_cell
      gmw_cell u_cell (
         .clock   (clock),
         .en      (en),
         .shift   (en && s1_v_ff),
         .ctl     (ctl),
         .col_on  (SPAN_W'(j) <= ctl.span),
         .col_in  ((j == 0) ? col_vec : cell_col[(j == 0) ? 0 : j - 1]),
         .col_out (cell_col[j]),
         .red_out (cell_red[j])
      );
   end

   pix_type res;
   always_comb begin
      res = ident(ctl.mode);
      for (int j = 0; j < WSIDE; j++) res = pick(res, cell_red[j], ctl.mode);
   end

   // output register and skid
   logic    new_v;
   rsp_type new_d;
   logic    main_v_ff;
   rsp_type main_ff, skid_ff;

   assign new_v = s3_v_ff && s3_meta_ff.emit;
   always_comb begin
      new_d.last = s3_meta_ff.last;
      new_d.oy   = s3_meta_ff.oy;
      new_d.ox   = s3_meta_ff.ox;
      new_d.res  = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_tready) skid_v_ff <= 1'b0;
      end else if (!main_v_ff || rsp_tready) begin
         main_v_ff <= new_v;
      end else if (new_v) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_tready) main_ff <= skid_ff;
      end else if (!main_v_ff || rsp_tready) begin
         main_ff <= new_d;
      end else if (new_v) begin
         skid_ff <= new_d;
      end
   end

   assign rsp_tvalid = main_v_ff;
   assign rsp_tdata  = {1'b0, main_ff.oy, main_ff.ox, main_ff.res};
   assign rsp_tlast  = main_ff.last;

   // checks
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> main_v_ff)
      else $error("skid holds data while result register is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      !skid_v_ff && main_v_ff && !rsp_tready && new_v |=> skid_v_ff)
      else $error("stalled result lost instead of caught by skid");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> !accept)
      else $error("pixel taken while skid occupied");

endmodule

`default_nettype wire
